// File: rtl/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg: shared types and constants for the coordinate LRU cache
// Word layouts of the request and result channels, command codes and
// default sizing of the tag store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcc_pkg;

    // Default number of entries in the tag store
    localparam int MAX_ENTRIES_DEF = 16;

    // Fixed field widths
    localparam int COORD_W = 32;
    localparam int CAP_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int OCC_W   = 5;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Command codes
    typedef enum logic [1:0] {
        CMD_ACCESS = 2'd0,
        CMD_PROBE  = 2'd1,
        CMD_EVICT  = 2'd2,
        CMD_CLEAR  = 2'd3
    } lcc_cmd_t;

    // Request word
    typedef struct packed {
        lcc_cmd_t                   command;
        logic signed [COORD_W-1:0]  chunk_x;
        logic signed [COORD_W-1:0]  chunk_z;
    } lcc_in_t;

    // Result word
    typedef struct packed {
        logic                       hit;
        logic                       evicted;
        logic signed [COORD_W-1:0]  evicted_x;
        logic signed [COORD_W-1:0]  evicted_z;
        logic [SLOT_W-1:0]          slot;
        logic [OCC_W-1:0]           occupancy;
    } lcc_out_t;

endpackage

// File: rtl/lcc_ram.sv
// ----------------------------------------------------------------------------
// lcc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lru_coordinate_cache.sv
// ----------------------------------------------------------------------------
// lru_coordinate_cache: fully associative LRU tag store keyed by (x,z)
// Sequence: a compare sweep over the key and rank RAMs, then for an access
//   that hits or fills a slot, or an evict hit, a rank rewrite sweep.
// One request at a time: in_ready is high only in idle, so a new word waits
//   until the last result has been loaded into the output register.
// Reset: store empty, capacity 16, no result pending; RAMs are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_coordinate_cache #(
    parameter int MAX_ENTRIES = lcc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  lcc_pkg::lcc_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output lcc_pkg::lcc_out_t         out_data,
    input  logic                      cfg_we,
    input  logic [lcc_pkg::CAP_W-1:0] cfg_wdata
);

    import lcc_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W = 2 * COORD_W;
    localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MAX_ENTRIES);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        UPD_MRU = 2'd0,
        UPD_INS = 2'd1,
        UPD_DEC = 2'd2
    } upd_t;

    // Control state
    state_t                 state_reg,     state_next;
    logic [CAP_W-1:0]       cap_reg,       cap_next;
    logic [CNT_W-1:0]       count_reg,     count_next;
    logic [MAX_ENTRIES-1:0] valid_reg,     valid_next;
    logic [CNT_W-1:0]       rd_idx_reg,    rd_idx_next;
    logic                   chk_en_reg,    chk_en_next;
    logic                   found_reg,     found_next;
    logic                   lru_found_reg, lru_found_next;
    logic                   free_found_reg, free_found_next;
    logic                   out_valid_reg, out_valid_next;

    // Payload state
    lcc_cmd_t               cmd_reg,        cmd_next;
    logic [KEY_W-1:0]       key_reg,        key_next;
    logic [IDX_W-1:0]       chk_idx_reg,    chk_idx_next;
    logic [IDX_W-1:0]       found_idx_reg,  found_idx_next;
    logic [IDX_W-1:0]       found_rank_reg, found_rank_next;
    logic [IDX_W-1:0]       lru_idx_reg,    lru_idx_next;
    logic [KEY_W-1:0]       lru_key_reg,    lru_key_next;
    logic [IDX_W-1:0]       free_idx_reg,   free_idx_next;
    upd_t                   upd_op_reg,     upd_op_next;
    logic [IDX_W-1:0]       tgt_idx_reg,    tgt_idx_next;
    logic [IDX_W-1:0]       pivot_reg,      pivot_next;
    logic                   res_hit_reg,    res_hit_next;
    logic                   res_evicted_reg, res_evicted_next;
    logic [IDX_W-1:0]       res_slot_reg,   res_slot_next;
    lcc_out_t               out_data_reg,   out_data_next;

    // RAM ports
    logic                   key_we;
    logic [IDX_W-1:0]       key_waddr;
    logic [KEY_W-1:0]       key_rdata;
    logic                   rank_we;
    logic [IDX_W-1:0]       rank_wdata;
    logic [IDX_W-1:0]       rank_rdata;

    // Sweep helpers
    logic                   accept;
    logic                   issue;
    logic                   ent_vld;
    logic [CNT_W-1:0]       cnt_dec;
    logic [IDX_W-1:0]       cnt_m1;
    logic [CW-1:0]          cap_w;
    logic [CW-1:0]          cnt_w;
    logic [CW-1:0]          max_w;
    logic [CW-1:0]          cap_sat;
    logic                   evict_now;
    logic                   has_free;
    logic [IDX_W-1:0]       ins_idx;

    assign accept  = in_valid && in_ready;
    assign issue   = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE))
                     && (rd_idx_reg != DEPTH_C);
    assign ent_vld = valid_reg[chk_idx_reg];
    assign cnt_dec = count_reg - CNT_W'(1);
    assign cnt_m1  = cnt_dec[IDX_W-1:0];

    // Effective capacity: zero acts as one, saturate at the store depth
    assign cap_w = CW'(cap_reg);
    assign cnt_w = CW'(count_reg);
    assign max_w = CW'(MAX_ENTRIES);
    always_comb
    begin
        if (cap_w == '0)
        begin
            cap_sat = CW'(1);
        end
        else if (cap_w > max_w)
        begin
            cap_sat = max_w;
        end
        else
        begin
            cap_sat = cap_w;
        end
    end

    // Miss handling: victim and lowest free entry after eviction
    assign evict_now = (cnt_w >= cap_sat) && (cnt_w != '0) && lru_found_reg;
    assign has_free  = free_found_reg || evict_now;
    assign ins_idx   = (evict_now && (!free_found_reg || (lru_idx_reg < free_idx_reg)))
                       ? lru_idx_reg : free_idx_reg;

    // Key and rank stores
    lcc_ram #(
        .WIDTH  (KEY_W),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_key_ram (
        .clk    (clk),
        .we     (key_we),
        .waddr  (key_waddr),
        .wdata  (key_reg),
        .raddr  (rd_idx_reg[IDX_W-1:0]),
        .rdata  (key_rdata)
    );

    lcc_ram #(
        .WIDTH  (IDX_W),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_rank_ram (
        .clk    (clk),
        .we     (rank_we),
        .waddr  (chk_idx_reg),
        .wdata  (rank_wdata),
        .raddr  (rd_idx_reg[IDX_W-1:0]),
        .rdata  (rank_rdata)
    );

    // Sequencer and datapath next state
    always_comb
    begin
        state_next       = state_reg;
        cap_next         = cfg_we ? cfg_wdata : cap_reg;
        count_next       = count_reg;
        valid_next       = valid_reg;
        rd_idx_next      = rd_idx_reg;
        chk_en_next      = 1'b0;
        chk_idx_next     = rd_idx_reg[IDX_W-1:0];
        found_next       = found_reg;
        lru_found_next   = lru_found_reg;
        free_found_next  = free_found_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        found_idx_next   = found_idx_reg;
        found_rank_next  = found_rank_reg;
        lru_idx_next     = lru_idx_reg;
        lru_key_next     = lru_key_reg;
        free_idx_next    = free_idx_reg;
        upd_op_next      = upd_op_reg;
        tgt_idx_next     = tgt_idx_reg;
        pivot_next       = pivot_reg;
        res_hit_next     = res_hit_reg;
        res_evicted_next = res_evicted_reg;
        res_slot_next    = res_slot_reg;
        out_data_next    = out_data_reg;
        key_we           = 1'b0;
        key_waddr        = ins_idx;
        rank_we          = 1'b0;
        rank_wdata       = rank_rdata;

        // Advance the shared read pointer during a sweep
        if (issue)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
            chk_en_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = in_data.command;
                    key_next        = {in_data.chunk_x, in_data.chunk_z};
                    rd_idx_next     = '0;
                    found_next      = 1'b0;
                    lru_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Compare one entry per cycle
                if (chk_en_reg)
                begin
                    if (ent_vld && (key_rdata == key_reg) && !found_reg)
                    begin
                        found_next      = 1'b1;
                        found_idx_next  = chk_idx_reg;
                        found_rank_next = rank_rdata;
                    end
                    if (ent_vld && (rank_rdata == cnt_m1) && !lru_found_reg)
                    begin
                        lru_found_next = 1'b1;
                        lru_idx_next   = chk_idx_reg;
                        lru_key_next   = key_rdata;
                    end
                    if (!ent_vld && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                end
                if (rd_idx_reg == DEPTH_C)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                res_hit_next     = found_reg;
                res_evicted_next = 1'b0;
                res_slot_next    = '0;
                rd_idx_next      = '0;
                state_next       = ST_FINISH;
                case (cmd_reg)
                    CMD_ACCESS:
                    begin
                        if (found_reg)
                        begin
                            upd_op_next   = UPD_MRU;
                            tgt_idx_next  = found_idx_reg;
                            pivot_next    = found_rank_reg;
                            res_slot_next = found_idx_reg;
                            state_next    = ST_UPDATE;
                        end
                        else
                        begin
                            res_evicted_next = evict_now;
                            if (evict_now)
                            begin
                                valid_next[lru_idx_reg] = 1'b0;
                            end
                            if (has_free)
                            begin
                                valid_next[ins_idx] = 1'b1;
                                key_we              = 1'b1;
                                upd_op_next         = UPD_INS;
                                tgt_idx_next        = ins_idx;
                                res_slot_next       = ins_idx;
                                state_next          = ST_UPDATE;
                            end
                            count_next = count_reg - CNT_W'(evict_now) + CNT_W'(has_free);
                        end
                    end
                    CMD_EVICT:
                    begin
                        if (found_reg)
                        begin
                            valid_next[found_idx_reg] = 1'b0;
                            count_next   = cnt_dec;
                            upd_op_next  = UPD_DEC;
                            tgt_idx_next = found_idx_reg;
                            pivot_next   = found_rank_reg;
                            state_next   = ST_UPDATE;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        valid_next = '0;
                        count_next = '0;
                    end
                    default:
                    begin
                        // Probe leaves the store as it is
                    end
                endcase
            end

            ST_UPDATE:
            begin
                // Rewrite one rank per cycle
                if (chk_en_reg)
                begin
                    rank_we = ent_vld;
                    case (upd_op_reg)
                        UPD_MRU:
                        begin
                            if (chk_idx_reg == tgt_idx_reg)
                            begin
                                rank_wdata = '0;
                            end
                            else if (rank_rdata < pivot_reg)
                            begin
                                rank_wdata = rank_rdata + IDX_W'(1);
                            end
                        end
                        UPD_INS:
                        begin
                            if (chk_idx_reg == tgt_idx_reg)
                            begin
                                rank_wdata = '0;
                            end
                            else
                            begin
                                rank_wdata = rank_rdata + IDX_W'(1);
                            end
                        end
                        UPD_DEC:
                        begin
                            if (rank_rdata > pivot_reg)
                            begin
                                rank_wdata = rank_rdata - IDX_W'(1);
                            end
                        end
                        default:
                        begin
                            rank_we = 1'b0;
                        end
                    endcase
                end
                if (rd_idx_reg == DEPTH_C)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.hit       = res_hit_reg;
                    out_data_next.evicted   = res_evicted_reg;
                    out_data_next.evicted_x = res_evicted_reg ? lru_key_reg[KEY_W-1:COORD_W]
                                                              : '0;
                    out_data_next.evicted_z = res_evicted_reg ? lru_key_reg[COORD_W-1:0]
                                                              : '0;
                    out_data_next.slot      = SLOT_W'(res_slot_reg);
                    out_data_next.occupancy = OCC_W'(count_reg);
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= CAP_RESET;
            count_reg      <= '0;
            valid_reg      <= '0;
            rd_idx_reg     <= '0;
            chk_en_reg     <= 1'b0;
            found_reg      <= 1'b0;
            lru_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
            rd_idx_reg     <= rd_idx_next;
            chk_en_reg     <= chk_en_next;
            found_reg      <= found_next;
            lru_found_reg  <= lru_found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        chk_idx_reg     <= chk_idx_next;
        found_idx_reg   <= found_idx_next;
        found_rank_reg  <= found_rank_next;
        lru_idx_reg     <= lru_idx_next;
        lru_key_reg     <= lru_key_next;
        free_idx_reg    <= free_idx_next;
        upd_op_reg      <= upd_op_next;
        tgt_idx_reg     <= tgt_idx_next;
        pivot_reg       <= pivot_next;
        res_hit_reg     <= res_hit_next;
        res_evicted_reg <= res_evicted_next;
        res_slot_reg    <= res_slot_next;
        out_data_reg    <= out_data_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/lcc_checker.sv
// ----------------------------------------------------------------------------
// lcc_checker: port-level checks for the coordinate LRU cache
// Watches the handshakes and result words of the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcc_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  lcc_pkg::lcc_out_t out_data
);

    import lcc_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // Drop ready while a word is being worked on
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // Evict only on a miss
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.evicted && out_data.hit))
        else $error("eviction reported on a hit");

    // Zero the victim key when nothing was pushed out
    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.evicted |-> (out_data.evicted_x == '0)
                                        && (out_data.evicted_z == '0))
        else $error("victim key not zero without eviction");

endmodule

bind lru_coordinate_cache lcc_checker u_lcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
